// ===== rtl/core/cstl_pkg.sv =====
package cstl_pkg;

  // Default sizes
  localparam int PositionBitsDefault = 16;
  localparam int KeywordCharsDefault = 8;

  // Keyword table: every keyword fits in eight bytes
  localparam int NumKeywords = 11;
  localparam int KwMaxChars  = 8;

  // Result queue depth (power of two), room for two tokens per byte plus slack
  localparam int OutQueueDepth = 4;

  // Output field widths
  localparam int TypeBits  = 5;
  localparam int FieldBits = 16;

  typedef enum logic [1:0] {
    ModeIdle   = 2'd0,
    ModeNumber = 2'd1,
    ModeName   = 2'd2,
    ModeEq     = 2'd3
  } mode_e;

  // Token type codes
  localparam logic [TypeBits-1:0] TtIdent   = 5'd0;
  localparam logic [TypeBits-1:0] TtInt     = 5'd12;
  localparam logic [TypeBits-1:0] TtLParen  = 5'd13;
  localparam logic [TypeBits-1:0] TtRParen  = 5'd14;
  localparam logic [TypeBits-1:0] TtLBrace  = 5'd15;
  localparam logic [TypeBits-1:0] TtRBrace  = 5'd16;
  localparam logic [TypeBits-1:0] TtLSquare = 5'd17;
  localparam logic [TypeBits-1:0] TtRSquare = 5'd18;
  localparam logic [TypeBits-1:0] TtAssign  = 5'd19;
  localparam logic [TypeBits-1:0] TtEqual   = 5'd20;
  localparam logic [TypeBits-1:0] TtPlus    = 5'd21;
  localparam logic [TypeBits-1:0] TtSemi    = 5'd22;
  localparam logic [TypeBits-1:0] TtEof     = 5'd23;
  localparam logic [TypeBits-1:0] TtError   = 5'd24;

  // Keywords in type order (type = index + 1), zero padded
  localparam logic [7:0] KwText [NumKeywords][KwMaxChars] = '{
    '{"v", "o", "i", "d", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
    '{"s", "w", "i", "t", "c", "h", 8'h00, 8'h00},
    '{"c", "a", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
    '{"c", "o", "n", "t", "i", "n", "u", "e"},
    '{"b", "r", "e", "a", "k", 8'h00, 8'h00, 8'h00}
  };

  localparam logic [7:0] KwLen [NumKeywords] = '{
    8'd4, 8'd3, 8'd2, 8'd4, 8'd3, 8'd5, 8'd6, 8'd4, 8'd6, 8'd8, 8'd5
  };

  typedef struct packed {
    logic [TypeBits-1:0]  tok_type;
    logic [FieldBits-1:0] start;
    logic [FieldBits-1:0] length;
    logic                 last;
  } token_t;

  function automatic logic num_char(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic alpha_char(input logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z")) || (c == "_");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
  endfunction

  function automatic logic [TypeBits-1:0] punct_type(input logic [7:0] c);
    logic [TypeBits-1:0] t;
    unique case (c)
      "(":     t = TtLParen;
      ")":     t = TtRParen;
      "{":     t = TtLBrace;
      "}":     t = TtRBrace;
      "[":     t = TtLSquare;
      "]":     t = TtRSquare;
      "+":     t = TtPlus;
      ";":     t = TtSemi;
      default: t = TtError;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/core/c_subset_token_lexer.sv =====
// Channel | Direction | Handshake               | Payload
// --------+-----------+-------------------------+------------------------------------------
// in      | input     | in_valid_i / in_stall_o  | char_code_i (one source byte per beat)
// out     | output    | out_valid_o / out_stall_i| token_type_o, token_start_o,
//         |           |                         | token_length_o, last_of_run_o
//
// One byte per cycle sustained while the result queue has two free slots. A byte
// lands in the input register, the scanner decodes it against the scan state and
// pushes zero, one or two tokens into a four-entry result queue; a token passes the
// input register and then the queue before it can leave. The queue sets the rate:
// the scanner moves a byte only while two queue slots are free, so bytes yielding
// two tokens can fill the queue faster than it drains. Reset clears the scan state,
// position and queue at once; the keyword prefix store is never cleared. A stalled
// output fills the queue; once fewer than two slots are free, the input register
// holds and in_stall_o rises.
module c_subset_token_lexer import cstl_pkg::*; #(
  parameter int POSITION_BITS = PositionBitsDefault,
  parameter int KEYWORD_CHARS = KeywordCharsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           char_code_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [TypeBits-1:0]  token_type_o,
  output logic [FieldBits-1:0] token_start_o,
  output logic [FieldBits-1:0] token_length_o,
  output logic                 last_of_run_o
);

  localparam int PrefIdxW = (KEYWORD_CHARS > 1) ? $clog2(KEYWORD_CHARS) : 1;
  localparam int PtrW     = $clog2(OutQueueDepth);
  localparam int CntW     = PtrW + 1;
  localparam logic [POSITION_BITS-1:0] PosMax = '1;
  localparam logic [CntW-1:0] PushLimit = CntW'(OutQueueDepth - 2);

  // Input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] char_q;
  logic       in_accept, proc_fire;

  // Scan state
  mode_e                    mode_q, mode_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS-1:0] pend_start_q, pend_start_d;
  logic [POSITION_BITS-1:0] pend_len_q, pend_len_d;
  logic [7:0]               prefix_q [KEYWORD_CHARS];

  // Result queue
  token_t          queue_q [OutQueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            pop;

  // Byte classes
  logic c_digit, c_letter, c_space, c_zero, c_eq, consumed;
  logic [TypeBits-1:0] kw_type;

  // Tokens raised by this byte: a ends a pending token, b comes from the byte itself
  logic                     a_valid, b_valid;
  logic [TypeBits-1:0]      a_type, b_type;
  logic [POSITION_BITS-1:0] a_start, a_len;
  token_t                   tok_first, tok_second;
  logic [1:0]               push_n;

  logic [POSITION_BITS-1:0] pos_inc, len_inc;

  // ---------------------------------------------------------------- handshake
  // Move a byte through the scanner only with room for two tokens.
  assign proc_fire  = in_valid_q && (count_q <= PushLimit);
  assign in_stall_o = in_valid_q && !proc_fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (proc_fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      char_q <= char_code_i;
    end
  end

  // ---------------------------------------------------------------- decode
  assign c_digit  = num_char(char_q);
  assign c_letter = alpha_char(char_q);
  assign c_space  = is_space(char_q);
  assign c_zero   = (char_q == 8'h00);
  assign c_eq     = (char_q == "=");

  assign pos_inc = (pos_q == PosMax) ? pos_q : pos_q + 1'b1;
  assign len_inc = (pend_len_q == PosMax) ? pend_len_q : pend_len_q + 1'b1;

  always_comb begin
    unique case (mode_q)
      ModeNumber: consumed = c_digit;
      ModeName:   consumed = c_digit || c_letter;
      ModeEq:     consumed = c_eq;
      default:    consumed = 1'b0;
    endcase
  end

  // Exact keyword match: same length and every keyword byte equal.
  always_comb begin
    logic hit;
    kw_type = TtIdent;
    for (int k = NumKeywords - 1; k >= 0; k--) begin
      hit = (pend_len_q == POSITION_BITS'(KwLen[k]));
      for (int i = 0; i < KwMaxChars; i++) begin
        if (i < int'(KwLen[k]) && prefix_q[i] != KwText[k][i]) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        kw_type = TypeBits'(k + 1);
      end
    end
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    mode_d = mode_q;
    if (proc_fire) begin
      if (consumed) begin
        mode_d = (mode_q == ModeEq) ? ModeIdle : mode_q;
      end else begin
        priority if (c_digit) begin
          mode_d = ModeNumber;
        end else if (c_letter) begin
          mode_d = ModeName;
        end else if (c_eq) begin
          mode_d = ModeEq;
        end else begin
          mode_d = ModeIdle;
        end
      end
    end
  end

  always_comb begin
    pos_d        = pos_q;
    pend_start_d = pend_start_q;
    pend_len_d   = pend_len_q;
    if (proc_fire) begin
      pos_d = c_zero ? '0 : pos_inc;
      if (consumed) begin
        if (mode_q == ModeNumber || mode_q == ModeName) begin
          pend_len_d = len_inc;
        end
      end else if (c_digit || c_letter || c_eq) begin
        pend_start_d = pos_q;
        pend_len_d   = POSITION_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ModeIdle;
      pos_q        <= '0;
      pend_start_q <= '0;
      pend_len_q   <= '0;
    end else begin
      mode_q       <= mode_d;
      pos_q        <= pos_d;
      pend_start_q <= pend_start_d;
      pend_len_q   <= pend_len_d;
    end
  end

  // Keep the first bytes of a name for the keyword compare.
  always_ff @(posedge clk_i) begin
    if (proc_fire) begin
      if (consumed && mode_q == ModeName) begin
        if (pend_len_q < POSITION_BITS'(KEYWORD_CHARS)) begin
          prefix_q[pend_len_q[PrefIdxW-1:0]] <= char_q;
        end
      end else if (!consumed && c_letter) begin
        prefix_q[0] <= char_q;
      end
    end
  end

  // ---------------------------------------------------------------- tokens
  always_comb begin
    a_valid = 1'b0;
    a_type  = TtIdent;
    a_start = pend_start_q;
    a_len   = pend_len_q;
    unique case (mode_q)
      ModeNumber: begin
        a_valid = !consumed;
        a_type  = TtInt;
      end
      ModeName: begin
        a_valid = !consumed;
        a_type  = kw_type;
      end
      ModeEq: begin
        a_valid = 1'b1;
        a_type  = consumed ? TtEqual : TtAssign;
        a_len   = consumed ? POSITION_BITS'(2) : POSITION_BITS'(1);
      end
      default: begin
        a_valid = 1'b0;
      end
    endcase
  end

  always_comb begin
    b_valid = 1'b0;
    b_type  = TtError;
    if (!consumed) begin
      priority if (c_zero) begin
        b_valid = 1'b1;
        b_type  = TtEof;
      end else if (c_space || c_digit || c_letter || c_eq) begin
        b_valid = 1'b0;
      end else begin
        b_valid = 1'b1;
        b_type  = punct_type(char_q);
      end
    end
  end

  always_comb begin
    tok_second.tok_type = b_type;
    tok_second.start    = FieldBits'(pos_q);
    tok_second.length   = FieldBits'(1);
    tok_second.last     = 1'b1;
    if (a_valid) begin
      tok_first.tok_type = a_type;
      tok_first.start    = FieldBits'(a_start);
      tok_first.length   = FieldBits'(a_len);
      tok_first.last     = !b_valid;
    end else begin
      tok_first = tok_second;
    end
    push_n = proc_fire ? (2'(a_valid) + 2'(b_valid)) : 2'd0;
  end

  // ---------------------------------------------------------------- result queue
  assign pop = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      queue_q[wr_ptr_q] <= tok_first;
    end
    if (push_n == 2'd2) begin
      queue_q[wr_ptr_q + 1'b1] <= tok_second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_n);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop);
      count_q  <= count_q + CntW'(push_n) - CntW'(pop);
    end
  end

  assign out_valid_o    = (count_q != '0);
  assign token_type_o   = queue_q[rd_ptr_q].tok_type;
  assign token_start_o  = queue_q[rd_ptr_q].start;
  assign token_length_o = queue_q[rd_ptr_q].length;
  assign last_of_run_o  = queue_q[rd_ptr_q].last;

endmodule
